@@ rtl/salc_pkg.sv @@
// shared types and constants for the set-associative lru cache
// no dependencies; imported by the way evaluator and the top module
package salc_pkg;

  localparam int TAG_IN_W  = 26;  // tag field width at the ports
  localparam int SET_IN_W  = 4;   // set index field width at the ports
  localparam int OFF_IN_W  = 2;   // word offset field width at the ports
  localparam int DATA_W    = 8;   // one byte per word
  localparam int WAY_MAX_W = 4;   // enough for up to 16 ways

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef logic [WAY_MAX_W-1:0] way_t;

  // control from the sequencer to the way evaluator
  typedef struct packed {
    logic start;  // clear trackers for a new access
    logic en;     // metadata of one way is on the inputs
  } scan_ctl_t;

  // outcome of a set scan
  typedef struct packed {
    logic hit;
    way_t hit_way;
    way_t victim_way;
  } scan_res_t;

endpackage

@@ rtl/salc_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/salc_way_eval.sv @@
// shared compare unit: takes one way's metadata a cycle and tracks
// tag hit, first invalid way and oldest way; depends on salc_pkg
module salc_way_eval #(
  parameter int TAG_BITS   = 26,
  parameter int AGE_BITS   = 16,
  parameter int STAMP_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  salc_pkg::scan_ctl_t    ctl,
  input  salc_pkg::way_t         way,
  input  logic                   line_valid,
  input  logic [TAG_BITS-1:0]    req_tag,
  input  logic [TAG_BITS-1:0]    line_tag,
  input  logic [STAMP_BITS-1:0]  now,
  input  logic [STAMP_BITS-1:0]  stamp,
  output salc_pkg::scan_res_t    res
);
  import salc_pkg::*;

  localparam logic [STAMP_BITS-1:0] AGE_SAT = STAMP_BITS'({AGE_BITS{1'b1}});

  logic [STAMP_BITS-1:0] diff;
  logic [AGE_BITS-1:0]   age;
  logic                  match;

  logic                  hit_r;
  logic                  inv_found_r;
  way_t                  hit_way_r;
  way_t                  inv_way_r;
  way_t                  best_way_r;
  logic [AGE_BITS-1:0]   best_age_r;

  // age is accesses since the last touch, saturated
  assign diff  = now - stamp;
  assign age   = (diff > AGE_SAT) ? {AGE_BITS{1'b1}} : diff[AGE_BITS-1:0];
  assign match = line_valid && (line_tag == req_tag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      inv_found_r <= 1'b0;
    end else if (ctl.start) begin
      hit_r       <= 1'b0;
      inv_found_r <= 1'b0;
    end else if (ctl.en) begin
      if (match) begin
        hit_r <= 1'b1;
      end
      if (!line_valid) begin
        inv_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (match && !hit_r) begin
        hit_way_r <= way;
      end
      if (!line_valid && !inv_found_r) begin
        inv_way_r <= way;
      end
      // strictly greater keeps the lowest way on a tie
      if ((way == '0) || (age > best_age_r)) begin
        best_age_r <= age;
        best_way_r <= way;
      end
    end
  end

  assign res.hit        = hit_r;
  assign res.hit_way    = hit_way_r;
  assign res.victim_way = inv_found_r ? inv_way_r : best_way_r;

endmodule

@@ rtl/set_associative_lru_cache_top.sv @@
// set-associative write-allocate byte cache with lru replacement
// a read miss or write hit answers after the scan from ST_ACT, a read hit goes on
// through ST_RDWAIT and a write miss through ST_FILL; the set scan reads one way's
// metadata a cycle through one compare unit, and a fill writes one byte a cycle
// one item at a time; the next input transfer may share the cycle of the result transfer
// synchronous active-low reset clears the valid bits, the access counter and control
module set_associative_lru_cache_top #(
  parameter int SETS     = 16,
  parameter int WAYS     = 4,
  parameter int WORDS    = 4,
  parameter int TAG_BITS = 26,
  parameter int AGE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [salc_pkg::TAG_IN_W-1:0]   in_addr_tag,
  input  logic [salc_pkg::SET_IN_W-1:0]   in_set_index,
  input  logic [salc_pkg::OFF_IN_W-1:0]   in_word_offset,
  input  logic [salc_pkg::DATA_W-1:0]     in_write_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [salc_pkg::DATA_W-1:0]     out_read_data
);
  import salc_pkg::*;

  localparam int LINES      = SETS * WAYS;
  localparam int BYTES      = LINES * WORDS;
  localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int OFF_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LINE_W     = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int BYTE_W     = (BYTES > 1) ? $clog2(BYTES) : 1;
  localparam int CNT_MAX    = (WAYS > WORDS) ? WAYS : WORDS;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);
  // wide access counter: ages come from counter minus the line's stamp
  localparam int STAMP_BITS = AGE_BITS + 32;
  localparam int META_W     = TAG_BITS + STAMP_BITS;
  localparam int SET_CODES  = 2 ** SET_IN_W;
  localparam int OFF_CODES  = 2 ** OFF_IN_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_ACT    = 6'b000100,
    ST_RDWAIT = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_SPARE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // set and offset reduction tables, built at elaboration
  logic [SET_W-1:0] set_lut [SET_CODES];
  logic [OFF_W-1:0] off_lut [OFF_CODES];

  for (genvar g = 0; g < SET_CODES; g++) begin : g_set_lut
    assign set_lut[g] = SET_W'(g % SETS);
  end
  for (genvar g = 0; g < OFF_CODES; g++) begin : g_off_lut
    assign off_lut[g] = OFF_W'(g % WORDS);
  end

  // captured request
  logic                  op_r;
  logic [TAG_BITS-1:0]   tag_r;
  logic [SET_W-1:0]      set_r;
  logic [OFF_W-1:0]      off_r;
  logic [DATA_W-1:0]     wdata_r;
  logic [TAG_IN_W+TAG_BITS-1:0] tag_ext;

  // sequencer state
  logic [STAMP_BITS-1:0] now_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  p_v_r;     // metadata read in flight last cycle
  way_t                  p_way_r;
  logic [LINE_W-1:0]     p_line_r;
  logic [LINE_W-1:0]     line_r;    // line being filled
  logic [LINES-1:0]      valid_r;

  // result register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [DATA_W-1:0]     out_rdata_r;

  logic                  in_xfer;
  logic                  out_xfer;
  logic [LINE_W-1:0]     line_base;
  logic [LINE_W-1:0]     hit_line;
  logic [LINE_W-1:0]     victim_line;
  logic                  scan_issue;
  logic                  scan_last;
  logic                  fill_last;

  // memories
  logic                  meta_we;
  logic [LINE_W-1:0]     meta_waddr;
  logic [META_W-1:0]     meta_wdata;
  logic                  meta_re;
  logic [LINE_W-1:0]     meta_raddr;
  logic [META_W-1:0]     meta_rdata;

  logic                  byte_we;
  logic [BYTE_W-1:0]     byte_waddr;
  logic [DATA_W-1:0]     byte_wdata;
  logic                  byte_re;
  logic [BYTE_W-1:0]     byte_raddr;
  logic [DATA_W-1:0]     byte_rdata;

  scan_ctl_t             scan_ctl;
  scan_res_t             scan_res;

  // handshakes: a waiting result may leave in the same cycle a new item enters
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid_r && out_ready;

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_read_data = out_rdata_r;

  // only the low TAG_BITS of the tag are kept
  assign tag_ext = {{TAG_BITS{1'b0}}, in_addr_tag};

  // line addressing
  assign line_base   = LINE_W'(set_r) * LINE_W'(WAYS);
  assign hit_line    = line_base + LINE_W'(scan_res.hit_way);
  assign victim_line = line_base + LINE_W'(scan_res.victim_way);

  assign scan_issue = (state_r == ST_SCAN) && (cnt_r < CNT_W'(WAYS));
  assign scan_last  = p_v_r && (p_way_r == way_t'(WAYS - 1));
  assign fill_last  = (cnt_r == CNT_W'(WORDS - 1));

  // metadata: one read per way during the scan, one write on hit or fill
  assign meta_re    = scan_issue;
  assign meta_raddr = line_base + LINE_W'(cnt_r);
  assign meta_we    = (state_r == ST_ACT) && (scan_res.hit || (op_r == OP_WRITE));
  assign meta_waddr = scan_res.hit ? hit_line : victim_line;
  assign meta_wdata = {tag_r, now_r};

  // bytes: a write hit stores one byte, a fill sweeps the whole block
  always_comb begin
    byte_we    = 1'b0;
    byte_waddr = BYTE_W'(hit_line) * BYTE_W'(WORDS) + BYTE_W'(off_r);
    byte_wdata = wdata_r;
    if ((state_r == ST_ACT) && scan_res.hit && (op_r == OP_WRITE)) begin
      byte_we = 1'b1;
    end else if (state_r == ST_FILL) begin
      byte_we    = 1'b1;
      byte_waddr = BYTE_W'(line_r) * BYTE_W'(WORDS) + BYTE_W'(cnt_r);
      byte_wdata = (cnt_r == CNT_W'(off_r)) ? wdata_r : '0;
    end
  end

  assign byte_re    = (state_r == ST_ACT) && scan_res.hit && (op_r == OP_READ);
  assign byte_raddr = BYTE_W'(hit_line) * BYTE_W'(WORDS) + BYTE_W'(off_r);

  // compare unit control
  assign scan_ctl.start = in_xfer;
  assign scan_ctl.en    = p_v_r;

  salc_ram #(
    .WIDTH (META_W),
    .DEPTH (LINES)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  salc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BYTES)
  ) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (byte_wdata),
    .re    (byte_re),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  salc_way_eval #(
    .TAG_BITS   (TAG_BITS),
    .AGE_BITS   (AGE_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_way_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .way        (p_way_r),
    .line_valid (valid_r[p_line_r]),
    .req_tag    (tag_r),
    .line_tag   (meta_rdata[META_W-1:STAMP_BITS]),
    .now        (now_r),
    .stamp      (meta_rdata[STAMP_BITS-1:0]),
    .res        (scan_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        if (scan_res.hit && (op_r == OP_READ)) begin
          state_nxt = ST_RDWAIT;
        end else if (!scan_res.hit && (op_r == OP_WRITE)) begin
          state_nxt = ST_FILL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        state_nxt = ST_IDLE;
      end
      ST_FILL: begin
        if (fill_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      cnt_r       <= '0;
      p_v_r       <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_v_r   <= scan_issue;

      if (out_xfer) begin
        out_valid_r <= 1'b0;
      end

      // every access ages all lines by one tick of the counter
      if (in_xfer) begin
        now_r <= now_r + 1'b1;
        cnt_r <= '0;
      end else if (scan_issue) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (state_r == ST_ACT) begin
        cnt_r <= '0;
      end else if (state_r == ST_FILL) begin
        cnt_r <= cnt_r + 1'b1;
      end

      if ((state_r == ST_ACT) && !scan_res.hit && (op_r == OP_WRITE)) begin
        valid_r[victim_line] <= 1'b1;
      end

      // result ready: read miss or write hit straight from the scan
      if ((state_r == ST_ACT) && !(scan_res.hit && (op_r == OP_READ))
          && !(!scan_res.hit && (op_r == OP_WRITE))) begin
        out_valid_r <= 1'b1;
      end
      if ((state_r == ST_RDWAIT) || ((state_r == ST_FILL) && fill_last)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= in_opcode;
      tag_r   <= tag_ext[TAG_BITS-1:0];
      set_r   <= set_lut[in_set_index];
      off_r   <= off_lut[in_word_offset];
      wdata_r <= in_write_data;
    end
    if (scan_issue) begin
      p_way_r  <= way_t'(cnt_r);
      p_line_r <= meta_raddr;
    end
    if (state_r == ST_ACT) begin
      line_r      <= victim_line;
      out_hit_r   <= scan_res.hit;
      out_rdata_r <= '0;
    end
    if (state_r == ST_RDWAIT) begin
      out_rdata_r <= byte_rdata;
    end
  end

  // valid bits are only ever set between resets
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r) >= $past($countones(valid_r))))
    else $error("valid line lost without reset");

  // nonzero read data only comes with a hit
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_rdata_r != '0)) |-> out_hit_r)
    else $error("read data without hit");

  // a fill only follows a write whose scan missed
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (!scan_res.hit && (op_r == OP_WRITE)))
    else $error("fill without write miss");

  // a result appears only after a processing state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_ACT || $past(state_r) == ST_RDWAIT
                            || $past(state_r) == ST_FILL))
    else $error("result raised outside processing");

endmodule
